// ===== rtl/wmo_pkg.sv =====
// ---------------------------------------------------------------------------
// wmo_pkg
// Shared types and constants for the wavetable morph oscillator.
// ---------------------------------------------------------------------------
package wmo_pkg;

    localparam int MEM_AW     = 17;
    localparam int MEM_DEPTH  = 1 << MEM_AW;
    localparam int RATE_W     = 18;
    localparam int TCNT_W     = 7;
    localparam int CFG_W      = 18;
    localparam int FREQ_W     = 24;
    localparam int POS_W      = 17;
    localparam int SAMP_W     = 16;
    localparam int TC_W       = 9;   // holds table counts up to 256
    localparam int ZQ_W       = 42;  // quotient bits of (rate << 24) / freq
    localparam int DVD_W      = 64;
    localparam int REM_W      = 26;
    localparam int CNT_W      = 6;

    localparam logic CFG_SAMPLE_RATE = 1'b0;
    localparam logic CFG_TABLE_COUNT = 1'b1;

    localparam logic [RATE_W-1:0] RATE_RST = 18'd48000;
    localparam logic [TCNT_W-1:0] TCNT_RST = 7'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVZ,
        ST_WRAP,
        ST_MUL,
        ST_SCALE,
        ST_RANGE,
        ST_DIVN,
        ST_IDX,
        ST_READ,
        ST_INT1,
        ST_INT2,
        ST_INT3,
        ST_OUT
    } wmo_state_t;

    typedef struct packed {
        logic       capture;
        logic       mem_wr;
        logic       inc_phase;
        logic       div_load_z;
        logic       div_load_n;
        logic       div_step;
        logic       wrap_upd;
        logic       mul_prod;
        logic       scale;
        logic       range_chk;
        logic       set_idx;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       int1;
        logic       int2;
        logic       int3;
        logic       out_load;
    } wmo_cmd_t;

    typedef struct packed {
        logic freq_pos;
        logic div_last;
        logic clamp_now;
        logic out_free;
    } wmo_status_t;

endpackage

// ===== rtl/wavetable_morph_oscillator_top.sv =====
// ---------------------------------------------------------------------------
// wavetable_morph_oscillator_top
// Wavetable oscillator with in-table and cross-table linear interpolation.
// ---------------------------------------------------------------------------
// Input channel (s_*): one beat is either a table load (s_action 0), which
// writes s_load_value at s_load_address in the table memory and
// gives no result, or a tick (s_action 1). A tick whose summed frequency is
// not positive gives no result and leaves the phase state alone.
// Result channel (m_*): one beat per productive tick, Q1.15 sample plus the
// index clamp flag, held in an output register.
// A tick runs on the shared one-bit-per-cycle divider: 42 steps for the
// period quotient and log2(WAVE_LEN)+16 for index and fraction, plus four
// table reads on the one memory port; a clamped index skips the second
// divide. Ticks are handled one at a time; the next beat is taken as soon
// as the result sits in the output register, even if the receiver has not
// taken it.
// Stall: while an untaken beat holds the output register, a result waits in
// the sequencer's last step; no new beat is taken until it can be written.
// Reset: sample_rate 48000, table_count 64, phase and carry cleared. Table
// memory is not cleared; load every word before a tick reads it.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index; the user
// writes it only while idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module wavetable_morph_oscillator_top #(
    parameter int WAVE_LEN   = 2048,
    parameter int MAX_TABLES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [wmo_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [wmo_pkg::MEM_AW-1:0]        s_load_address,
    input  logic signed [wmo_pkg::SAMP_W-1:0] s_load_value,
    input  logic signed [wmo_pkg::FREQ_W-1:0] s_note_freq,
    input  logic signed [wmo_pkg::FREQ_W-1:0] s_bend_freq,
    input  logic [wmo_pkg::POS_W-1:0]         s_table_pos,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [wmo_pkg::SAMP_W-1:0] m_sample_out,
    output logic                              m_index_clamped
);
    import wmo_pkg::*;

    wmo_cmd_t    cmd;
    wmo_status_t status;

    wmo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wmo_datapath #(
        .WAVE_LEN   (WAVE_LEN),
        .MAX_TABLES (MAX_TABLES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_load_address  (s_load_address),
        .s_load_value    (s_load_value),
        .s_note_freq     (s_note_freq),
        .s_bend_freq     (s_bend_freq),
        .s_table_pos     (s_table_pos),
        .m_sample_out    (m_sample_out),
        .m_index_clamped (m_index_clamped),
        .m_valid         (m_valid),
        .m_ready         (m_ready)
    );

endmodule

// ===== rtl/wmo_ctrl.sv =====
// ---------------------------------------------------------------------------
// wmo_ctrl
// Sequencer: walks one tick through divide, wrap, index, reads and blend.
// ---------------------------------------------------------------------------
module wmo_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_action,
    output logic                 s_ready,
    input  wmo_pkg::wmo_status_t status,
    output wmo_pkg::wmo_cmd_t    cmd
);
    import wmo_pkg::*;

    wmo_state_t state_reg, state_next;
    logic [1:0] rd_cnt_reg, rd_cnt_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= 2'd0;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_action) state_next = ST_CHECK;
            end
            ST_CHECK: state_next = status.freq_pos ? ST_DIVZ : ST_IDLE;
            ST_DIVZ: begin
                if (status.div_last) state_next = ST_WRAP;
            end
            ST_WRAP:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_RANGE;
            ST_RANGE: state_next = status.clamp_now ? ST_IDX : ST_DIVN;
            ST_DIVN: begin
                if (status.div_last) state_next = ST_IDX;
            end
            ST_IDX: begin
                state_next  = ST_READ;
                rd_cnt_next = 2'd0;
            end
            ST_READ: begin
                rd_cnt_next = rd_cnt_reg + 2'd1;
                if (rd_cnt_reg == 2'd3) state_next = ST_INT1;
            end
            ST_INT1: state_next = ST_INT2;
            ST_INT2: state_next = ST_INT3;
            ST_INT3: state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.rd_sel = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = accept && s_action;
                cmd.mem_wr  = accept && !s_action;
            end
            ST_CHECK: begin
                cmd.inc_phase  = status.freq_pos;
                cmd.div_load_z = status.freq_pos;
            end
            ST_DIVZ:  cmd.div_step   = 1'b1;
            ST_WRAP:  cmd.wrap_upd   = 1'b1;
            ST_MUL:   cmd.mul_prod   = 1'b1;
            ST_SCALE: cmd.scale      = 1'b1;
            ST_RANGE: begin
                cmd.range_chk  = 1'b1;
                cmd.div_load_n = 1'b1;
            end
            ST_DIVN:  cmd.div_step   = 1'b1;
            ST_IDX:   cmd.set_idx    = 1'b1;
            ST_READ:  cmd.rd_en      = 1'b1;
            ST_INT1:  cmd.int1       = 1'b1;
            ST_INT2:  cmd.int2       = 1'b1;
            ST_INT3:  cmd.int3       = 1'b1;
            ST_OUT:   cmd.out_load   = status.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// ===== rtl/wmo_datapath.sv =====
// ---------------------------------------------------------------------------
// wmo_datapath
// Table memory, phase state, shared radix-2 divider and the blend arithmetic.
// ---------------------------------------------------------------------------
module wmo_datapath #(
    parameter int WAVE_LEN   = 2048,
    parameter int MAX_TABLES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wmo_pkg::wmo_cmd_t             cmd,
    output wmo_pkg::wmo_status_t          status,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [wmo_pkg::CFG_W-1:0]     cfg_data,
    input  logic [wmo_pkg::MEM_AW-1:0]    s_load_address,
    input  logic signed [wmo_pkg::SAMP_W-1:0] s_load_value,
    input  logic signed [wmo_pkg::FREQ_W-1:0] s_note_freq,
    input  logic signed [wmo_pkg::FREQ_W-1:0] s_bend_freq,
    input  logic [wmo_pkg::POS_W-1:0]     s_table_pos,
    output logic signed [wmo_pkg::SAMP_W-1:0] m_sample_out,
    output logic                          m_index_clamped,
    output logic                          m_valid,
    input  logic                          m_ready
);
    import wmo_pkg::*;

    localparam int NW   = $clog2(WAVE_LEN);
    localparam int NQ   = NW + 16;
    localparam int HALF = WAVE_LEN / 2;
    localparam logic [63:0]     OVF_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 64'(HALF);
    localparam logic [TC_W-1:0] MAX_TC  = TC_W'(MAX_TABLES);
    localparam logic [NW-1:0]   N_LAST  = NW'(WAVE_LEN - 1);

    logic signed [SAMP_W-1:0] mem [MEM_DEPTH];

    logic [RATE_W-1:0] rate_cfg_reg;
    logic [TCNT_W-1:0] tcnt_cfg_reg;

    logic signed [FREQ_W:0] freq_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [31:0]            phase_reg;
    logic [16:0]            carry_reg;

    logic [REM_W-1:0] rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [REM_W-1:0] dsr_reg;
    logic [ZQ_W-1:0]  quo_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [55:0]  prod_reg;
    logic [63:0]  num_reg;
    logic         ovf_reg;
    logic         clamp_reg;
    logic [NW-1:0] n_reg, nn_reg;
    logic [15:0]  dn_reg;
    logic [7:0]   w_reg, ww_reg;
    logic [15:0]  dw_reg;
    logic signed [SAMP_W-1:0] samp_reg [4];
    logic signed [33:0] o1_reg, o2_reg;
    logic signed [49:0] acc_reg;

    logic signed [SAMP_W-1:0] out_sample_reg;
    logic                     out_clamp_reg;
    logic                     m_valid_reg;

    // derived config
    logic [RATE_W-1:0] rate_eff;
    logic [TC_W-1:0]   tc_eff, tc_m1;
    logic [25:0]       tprod;
    logic [8:0]        w_inc;
    logic [23:0]       f_val;
    logic [REM_W-1:0]  den;
    logic [63:0]       lim;
    logic              clamp_now;

    assign rate_eff = (rate_cfg_reg == '0) ? RATE_W'(1) : rate_cfg_reg;
    always_comb begin
        if (tcnt_cfg_reg == '0)
            tc_eff = TC_W'(1);
        else if (TC_W'(tcnt_cfg_reg) > MAX_TC)
            tc_eff = MAX_TC;
        else
            tc_eff = TC_W'(tcnt_cfg_reg);
    end
    assign tc_m1 = tc_eff - TC_W'(1);
    assign tprod = 26'(tc_m1) * 26'(pos_reg);
    assign w_inc = {1'b0, tprod[23:16]} + 9'd1;
    assign f_val = freq_reg[FREQ_W-1:0];
    assign den   = {rate_eff, 8'd0};
    assign lim   = 64'(den) * 64'(WAVE_LEN);
    assign clamp_now = ovf_reg || (num_reg >= lim);

    // divider step
    logic [REM_W:0]   rem_sh;
    logic             q_bit;
    logic [REM_W-1:0] rem_new;
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign q_bit   = rem_sh >= {1'b0, dsr_reg};
    assign rem_new = q_bit ? REM_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[REM_W-1:0];

    // wrap test: phase << 16 against 2z - carry
    logic signed [49:0] lhs, rhs;
    logic [17:0]        carry_sum;
    logic [16:0]        carry_new;
    assign lhs       = $signed({2'b0, phase_reg, 16'd0});
    assign rhs       = $signed({7'd0, quo_reg, 1'b0}) - $signed({33'd0, carry_reg});
    assign carry_sum = {1'b0, carry_reg} + {2'b0, quo_reg[15:0]};
    assign carry_new = (carry_sum > 18'd65536) ? 17'(carry_sum - 18'd65536)
                                               : carry_sum[16:0];

    // table addresses
    logic [MEM_AW-1:0] base1, base2, rd_addr;
    assign base1 = MEM_AW'(32'(w_reg) * 32'(WAVE_LEN));
    assign base2 = MEM_AW'(32'(ww_reg) * 32'(WAVE_LEN));
    always_comb begin
        case (cmd.rd_sel)
            2'd0:    rd_addr = base1 + MEM_AW'(n_reg);
            2'd1:    rd_addr = base1 + MEM_AW'(nn_reg);
            2'd2:    rd_addr = base2 + MEM_AW'(n_reg);
            default: rd_addr = base2 + MEM_AW'(nn_reg);
        endcase
    end

    // inner interpolation, shared between the two tables
    logic signed [SAMP_W-1:0] sa, sb;
    logic signed [16:0]       sdiff;
    logic signed [33:0]       o_new;
    assign sa    = cmd.int2 ? samp_reg[2] : samp_reg[0];
    assign sb    = cmd.int2 ? samp_reg[3] : samp_reg[1];
    assign sdiff = 17'(sb) - 17'(sa);
    assign o_new = (34'(sa) <<< 16) + 34'(sdiff * $signed({1'b0, dn_reg}));

    logic signed [34:0] odiff;
    logic signed [49:0] acc_new, acc_rnd;
    assign odiff   = 35'(o2_reg) - 35'(o1_reg);
    assign acc_new = (50'(o1_reg) <<< 16) + 50'(odiff * $signed({1'b0, dw_reg}));
    assign acc_rnd = acc_reg + 50'sd2147483648;

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) mem[s_load_address] <= s_load_value;
        if (cmd.rd_en)  samp_reg[cmd.rd_sel] <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_cfg_reg <= RATE_RST;
            tcnt_cfg_reg <= TCNT_RST;
            phase_reg    <= '0;
            carry_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_SAMPLE_RATE) rate_cfg_reg <= cfg_data[RATE_W-1:0];
                else                              tcnt_cfg_reg <= cfg_data[TCNT_W-1:0];
            end
            if (cmd.inc_phase) phase_reg <= phase_reg + 32'd1;
            if (cmd.wrap_upd && (lhs > rhs)) begin
                phase_reg <= '0;
                carry_reg <= carry_new;
            end
            if (cmd.out_load)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            freq_reg <= (FREQ_W+1)'(s_note_freq) + (FREQ_W+1)'(s_bend_freq);
            pos_reg  <= (s_table_pos > 17'd65536) ? 17'd65536 : s_table_pos;
        end
        if (cmd.div_load_z) begin
            rem_reg <= '0;
            dvd_reg <= {rate_eff, 46'd0};
            dsr_reg <= REM_W'(f_val);
            cnt_reg <= CNT_W'(ZQ_W);
        end else if (cmd.div_load_n) begin
            rem_reg <= REM_W'(num_reg >> NW);
            dvd_reg <= num_reg << (DVD_W - NW);
            dsr_reg <= den;
            cnt_reg <= CNT_W'(NQ);
        end else if (cmd.div_step) begin
            rem_reg <= rem_new;
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[ZQ_W-2:0], q_bit};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.wrap_upd) begin
            w_reg  <= tprod[23:16];
            ww_reg <= (w_inc == tc_eff) ? 8'd0 : w_inc[7:0];
            dw_reg <= tprod[15:0];
        end
        if (cmd.mul_prod)  prod_reg  <= 56'(phase_reg) * 56'(f_val);
        if (cmd.scale) begin
            num_reg <= 64'(64'(prod_reg) * 64'(HALF));
            ovf_reg <= 64'(prod_reg) > OVF_LIM;
        end
        if (cmd.range_chk) clamp_reg <= clamp_now;
        if (cmd.set_idx) begin
            if (clamp_reg) begin
                n_reg  <= N_LAST;
                nn_reg <= (N_LAST == NW'(WAVE_LEN - 1)) ? '0 : N_LAST + NW'(1);
                dn_reg <= '0;
            end else begin
                n_reg  <= quo_reg[NQ-1:16];
                nn_reg <= (quo_reg[NQ-1:16] == N_LAST) ? '0 : quo_reg[NQ-1:16] + NW'(1);
                dn_reg <= quo_reg[15:0];
            end
        end
        if (cmd.int1) o1_reg  <= o_new;
        if (cmd.int2) o2_reg  <= o_new;
        if (cmd.int3) acc_reg <= acc_new;
        if (cmd.out_load) begin
            out_sample_reg <= acc_rnd[47:32];
            out_clamp_reg  <= clamp_reg;
        end
    end

    assign status.freq_pos  = !freq_reg[FREQ_W] && (freq_reg != '0);
    assign status.div_last  = (cnt_reg == CNT_W'(1));
    assign status.clamp_now = clamp_now;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_sample_out    = out_sample_reg;
    assign m_index_clamped = out_clamp_reg;
    assign m_valid         = m_valid_reg;

    a_carry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        carry_reg <= 17'd65536)
        else $error("fraction carry out of range");

    a_clamp_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_idx && clamp_reg |=> (dn_reg == '0) && (n_reg == N_LAST))
        else $error("clamped index not forced to last sample");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrites an untaken beat");

endmodule

// ===== bench/tb_wavetable_morph_oscillator_top.sv =====
// ---------------------------------------------------------------------------
// tb_wavetable_morph_oscillator_top
// Self-checking bench for the wavetable morph oscillator.
// ---------------------------------------------------------------------------
// Table loads and ticks go in through the s_ channel in random bursts. Any
// table word that a tick will read is loaded first, so a word is never read
// before it is written. An in-bench fixed-point model of phase, interpolation
// and morphing predicts each output beat. The receiver stalls on its own
// pattern and once holds off for a long stretch. Sample rate and table count
// are changed between phases, extremes included.
// ---------------------------------------------------------------------------
module tb_wavetable_morph_oscillator_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wmo_pkg::*;

    localparam int  WAVE_LEN    = 2048;
    localparam int  MAX_TABLES  = 64;
    localparam int  TICK_CYCLES = 120;
    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam bit  ACT_LOAD    = 1'b0;
    localparam bit  ACT_TICK    = 1'b1;

    typedef struct {
        bit                      action;
        bit [MEM_AW-1:0]         addr;
        bit signed [SAMP_W-1:0]  value;
        bit signed [FREQ_W-1:0]  note;
        bit signed [FREQ_W-1:0]  bend;
        bit [POS_W-1:0]          pos;
    } osc_beat_t;

    typedef struct {
        bit signed [SAMP_W-1:0] sample;
        bit                     clamped;
    } osc_sample_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_index = 1'b0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_action = 1'b0;
    logic [MEM_AW-1:0]         s_load_address = '0;
    logic signed [SAMP_W-1:0]  s_load_value = '0;
    logic signed [FREQ_W-1:0]  s_note_freq = '0;
    logic signed [FREQ_W-1:0]  s_bend_freq = '0;
    logic [POS_W-1:0]          s_table_pos = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [SAMP_W-1:0]  m_sample_out;
    logic                      m_index_clamped;

    wavetable_morph_oscillator_top #(.WAVE_LEN(WAVE_LEN), .MAX_TABLES(MAX_TABLES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_load_address(s_load_address), .s_load_value(s_load_value),
        .s_note_freq(s_note_freq), .s_bend_freq(s_bend_freq), .s_table_pos(s_table_pos),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample_out(m_sample_out),
        .m_index_clamped(m_index_clamped)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // model state
    bit signed [SAMP_W-1:0] wave_mem [MEM_DEPTH];
    bit                     word_loaded [MEM_DEPTH];
    bit [31:0]              phase_cnt;
    bit [16:0]              frac_carry;
    bit [RATE_W-1:0]        rate_reg;
    bit [TCNT_W-1:0]        tcount_reg;

    osc_sample_t expected_samples[$];
    int unsigned errors;
    int unsigned cycle_cnt;
    int          burst_left;
    bit          hold_off;

    // Computes one beat; commit updates memory, phase and carry.
    function automatic bit osc_eval(input osc_beat_t b, input bit commit,
                                    output bit [MEM_AW-1:0] rd_addr[4],
                                    output osc_sample_t r);
        longint          freq, lhs, rhs, dn, dw, o1, o2, acc, res;
        longint          smp[4];
        longint unsigned f, rate, tc, pos, tprod, w, ww, z, den, prod, num, n, nn;
        bit [31:0]       ph;
        bit [31:0]       c;
        bit [16:0]       cr;
        bit              clamp;
        r = '{default: 0};
        rd_addr = '{default: 0};
        if (b.action == ACT_LOAD) begin
            if (commit) begin
                wave_mem[b.addr] = b.value;
                word_loaded[b.addr] = 1'b1;
            end
            return 1'b0;
        end
        freq = longint'(b.note) + longint'(b.bend);
        if (freq <= 0) return 1'b0;
        f = freq;
        rate = (rate_reg == 0) ? 1 : rate_reg;
        tc = (tcount_reg == 0) ? 1 : tcount_reg;
        if (tc > MAX_TABLES) tc = MAX_TABLES;
        pos = (b.pos > 65536) ? 65536 : b.pos;
        tprod = (tc - 1) * pos;
        w = tprod >> 16;
        dw = longint'(tprod & 64'hFFFF);
        ww = (w + 1) % tc;

        ph = phase_cnt + 1;
        cr = frac_carry;
        z = (rate << 24) / f;
        lhs = longint'(ph) << 16;
        rhs = 2 * longint'(z) - longint'(cr);
        if (lhs > rhs) begin
            c = 32'(cr) + 32'(z & 64'hFFFF);
            if (c > 65536) c = c - 65536;
            cr = c[16:0];
            ph = 0;
        end

        den = rate * 256;
        prod = longint'(ph) * f;
        clamp = 1'b0;
        n = 0;
        dn = 0;
        if (prod > 64'hFFFF_FFFF_FFFF_FFFF / (WAVE_LEN / 2)) begin
            clamp = 1'b1;
        end else begin
            num = prod * (WAVE_LEN / 2);
            n = num / den;
            if (n >= WAVE_LEN) clamp = 1'b1;
            else dn = longint'(((num % den) << 16) / den);
        end
        if (clamp) begin
            n = WAVE_LEN - 1;
            dn = 0;
        end
        nn = (n + 1) % WAVE_LEN;

        rd_addr[0] = MEM_AW'(w * WAVE_LEN + n);
        rd_addr[1] = MEM_AW'(w * WAVE_LEN + nn);
        rd_addr[2] = MEM_AW'(ww * WAVE_LEN + n);
        rd_addr[3] = MEM_AW'(ww * WAVE_LEN + nn);
        for (int i = 0; i < 4; i++) smp[i] = longint'(wave_mem[rd_addr[i]]);
        o1 = smp[1] * dn + smp[0] * (65536 - dn);
        o2 = smp[3] * dn + smp[2] * (65536 - dn);
        acc = o2 * dw + o1 * (65536 - dw);
        res = ((acc + (64'sd1 <<< 48) + (64'sd1 <<< 31)) >>> 32) - 65536;
        r.sample = res[15:0];
        r.clamped = clamp;
        if (commit) begin
            phase_cnt = ph;
            frac_carry = cr;
        end
        return 1'b1;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected beat: sample_out %0d index_clamped %0d",
                       m_sample_out, m_index_clamped);
                errors++;
            end else begin
                osc_sample_t e;
                e = expected_samples.pop_front();
                if (m_sample_out !== e.sample) begin
                    $error("sample_out: expected %0d, got %0d", e.sample, m_sample_out);
                    errors++;
                end
                if (m_index_clamped !== e.clamped) begin
                    $error("index_clamped: expected %0d, got %0d", e.clamped, m_index_clamped);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern: free-running, cycling through always ready, random and mostly stalled
    always @(posedge aclk) begin
        int unsigned mode;
        mode = (cycle_cnt / 300) % 3;
        if (hold_off) m_ready <= 1'b0;
        else if (mode == 0) m_ready <= 1'b1;
        else if (mode == 1) m_ready <= $urandom_range(0, 1);
        else m_ready <= ($urandom_range(0, 7) == 0);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_beat(input osc_beat_t b);
        bit [MEM_AW-1:0] addrs[4];
        osc_sample_t r;
        int gap;
        s_valid        <= 1'b1;
        s_action       <= b.action;
        s_load_address <= b.addr;
        s_load_value   <= b.value;
        s_note_freq    <= b.note;
        s_bend_freq    <= b.bend;
        s_table_pos    <= b.pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (osc_eval(b, 1'b1, addrs, r)) expected_samples.push_back(r);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic osc_beat_t rand_beat(input bit action);
        osc_beat_t b;
        b.action = action;
        b.addr   = MEM_AW'($urandom);
        b.value  = SAMP_W'($urandom);
        b.note   = FREQ_W'($urandom);
        b.bend   = FREQ_W'($urandom);
        b.pos    = POS_W'($urandom);
        return b;
    endfunction

    // loads every table word the tick will read that is still unwritten
    task automatic send_tick(input osc_beat_t b);
        bit [MEM_AW-1:0] addrs[4];
        osc_sample_t r;
        osc_beat_t   ld;
        b.action = ACT_TICK;
        if (osc_eval(b, 1'b0, addrs, r)) begin
            foreach (addrs[i]) begin
                if (!word_loaded[addrs[i]]) begin
                    ld = rand_beat(ACT_LOAD);
                    ld.addr = addrs[i];
                    send_beat(ld);
                end
            end
        end
        send_beat(b);
    endtask

    task automatic send_freq_tick(input longint freq, input bit [POS_W-1:0] pos);
        osc_beat_t b;
        longint bend;
        b = rand_beat(ACT_TICK);
        bend = longint'($urandom_range(0, 2000)) - 1000;
        if (freq - bend > 8388607) bend = freq - 8388607;
        b.note = FREQ_W'(freq - bend);
        b.bend = FREQ_W'(bend);
        b.pos  = pos;
        send_tick(b);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (TICK_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SAMPLE_RATE) rate_reg = RATE_W'(value);
        else tcount_reg = TCNT_W'(value);
    endtask

    task automatic test_extreme_loads;
        osc_beat_t b;
        b = rand_beat(ACT_LOAD);
        b.addr = '0; b.value = 16'sh7FFF;
        send_beat(b);
        b.addr = '1; b.value = 16'sh8000;
        send_beat(b);
        b.addr = 17'd2047; b.value = 16'sh8000;
        send_beat(b);
    endtask

    task automatic test_table_pos_range;
        send_freq_tick(1_000_000, 0);
        send_freq_tick(1_000_000, 65536);
        send_freq_tick(1_000_000, 17'h1FFFF);
        send_freq_tick(1_000_000, 32768);
        send_freq_tick(1_000_000, 65535);
    endtask

    task automatic test_nonpositive_freq;
        osc_beat_t b;
        b = rand_beat(ACT_TICK);
        b.note = 0; b.bend = 0;
        send_tick(b);
        b.note = 24'sh800000; b.bend = 24'sh7FFFFF;   // sums to minus one
        send_tick(b);
        b.note = 24'sh800000; b.bend = 24'sh800000;
        send_tick(b);
        b.note = 24'sh000001; b.bend = 24'shFFFFFF;
        send_tick(b);
    endtask

    task automatic test_freq_extremes;
        osc_beat_t b;
        b = rand_beat(ACT_TICK);
        b.note = 24'sh7FFFFF; b.bend = 24'sh7FFFFF;
        for (int i = 0; i < 3; i++) send_tick(b);
        b.note = 24'sh000001; b.bend = 24'sh000000;
        send_tick(b);
        b.note = 24'sh800000; b.bend = 24'sh7FFFFF; b.bend = b.bend;
        b.note = 24'sh7FFFFF; b.bend = 24'sh800001;   // sums to zero
        send_tick(b);
        // sweep through a short period
        for (int i = 0; i < 6; i++)
            send_freq_tick(3_000_000, POS_W'($urandom_range(0, 65536)));
    endtask

    task automatic test_config_extremes;
        int unsigned rates[4] = '{8000, 192000, 0, 262143};
        int unsigned counts[4] = '{1, 0, 127, 64};
        for (int k = 0; k < 4; k++) begin
            drain();
            write_reg(CFG_SAMPLE_RATE, rates[k]);
            write_reg(CFG_TABLE_COUNT, counts[k]);
            for (int i = 0; i < 3; i++)
                send_freq_tick(longint'($urandom_range(1, 8388607)),
                               POS_W'($urandom_range(0, 65536)));
        end
    endtask

    task automatic random_items(input int count);
        longint rate, freq;
        osc_beat_t b;
        for (int i = 0; i < count; i++) begin
            rate = (rate_reg == 0) ? 1 : rate_reg;
            case ($urandom_range(0, 9))
                0: send_beat(rand_beat(ACT_LOAD));
                1: send_tick(rand_beat(ACT_TICK));
                default: begin
                    // period of 3 to 200 ticks
                    freq = rate * 512 / $urandom_range(3, 200);
                    if (freq < 1) freq = 1;
                    if (freq > 16777214) freq = 16777214;
                    send_freq_tick(freq, ($urandom_range(0, 15) == 0) ?
                                   POS_W'($urandom) : POS_W'($urandom_range(0, 65536)));
                end
            endcase
        end
    endtask

    task automatic test_random_settings;
        for (int k = 0; k < 4; k++) begin
            drain();
            write_reg(CFG_SAMPLE_RATE, $urandom_range(8000, 192000));
            write_reg(CFG_TABLE_COUNT, $urandom_range(1, 64));
            random_items(25);
        end
    endtask

    task automatic test_backpressure;
        drain();
        write_reg(CFG_SAMPLE_RATE, 48000);
        write_reg(CFG_TABLE_COUNT, 64);
        fork
            begin
                hold_off <= 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off <= 1'b0;
            end
            random_items(15);
        join
    endtask

    initial begin
        rate_reg   = RATE_RST;
        tcount_reg = TCNT_RST;
        burst_left = 1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_loads();
        test_table_pos_range();
        test_nonpositive_freq();
        test_freq_extremes();
        test_config_extremes();
        test_random_settings();
        test_backpressure();
        drain();
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
